FILE: rtl/rfce_pkg.sv
// Shared constants and types for the framed receive buffer with echo.
package rfce_pkg;

    localparam int DEPTH = 64;
    localparam int CW = $clog2(DEPTH);

    localparam logic [7:0] MARKER_BYTE = 8'h55;
    localparam logic [7:0] CLOSE_BYTE = 8'hAA;

    typedef logic [CW-1:0] t_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic       wr_en;
        t_idx       wr_addr;
        logic [7:0] wr_data;
        logic       rd_en;
        t_idx       rd_addr;
    } t_buf_req;

endpackage

FILE: rtl/rfce_buf.sv
// Payload store with one write port and one registered read port.
module rfce_buf (
    input  logic              i_clk,
    input  rfce_pkg::t_buf_req i_req,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [rfce_pkg::DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/rfce_ctl.sv
// Frame sequencer: collects bytes, checks the closing pair and steps the echo.
module rfce_ctl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_timeout_flag,
    input  logic               i_read_error,
    output logic               o_stall,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic               o_last,
    output rfce_pkg::t_buf_req o_buf
);

    rfce_pkg::t_state r_state, n_state;
    rfce_pkg::t_idx   r_count, n_count;
    rfce_pkg::t_idx   r_idx, n_idx;
    logic             r_marker, n_marker;
    logic             w_last;

    assign w_last = (r_idx == r_count - rfce_pkg::CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rfce_pkg::ST_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_marker <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_marker <= n_marker;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_marker    = r_marker;
        o_stall     = 1'b1;
        o_out_valid = 1'b0;
        o_last      = 1'b0;
        o_buf       = '0;
        o_buf.wr_addr = r_count;
        o_buf.wr_data = i_rx_byte;
        o_buf.rd_addr = r_idx;
        case (r_state)
            rfce_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid && !i_read_error) begin
                    if (r_marker) begin
                        n_marker = 1'b0;
                        if (i_rx_byte == rfce_pkg::CLOSE_BYTE && !i_timeout_flag
                                && r_count != '0) begin
                            n_state = rfce_pkg::ST_READ;
                            n_idx   = '0;
                        end else begin
                            n_count = '0;
                        end
                    end else if (i_rx_byte == rfce_pkg::MARKER_BYTE) begin
                        n_marker = 1'b1;
                    end else begin
                        o_buf.wr_en = 1'b1;
                        if (r_count == rfce_pkg::CW'(rfce_pkg::DEPTH - 1)) begin
                            n_count = '0;
                        end else begin
                            n_count = r_count + rfce_pkg::CW'(1);
                        end
                    end
                end
            end
            rfce_pkg::ST_READ: begin
                o_buf.rd_en = 1'b1;
                n_state     = rfce_pkg::ST_SEND;
            end
            rfce_pkg::ST_SEND: begin
                o_out_valid = 1'b1;
                o_last      = w_last;
                if (!i_out_stall) begin
                    if (w_last) begin
                        n_state = rfce_pkg::ST_IDLE;
                        n_count = '0;
                    end else begin
                        n_idx   = r_idx + rfce_pkg::CW'(1);
                        n_state = rfce_pkg::ST_READ;
                    end
                end
            end
            default: begin
                n_state = rfce_pkg::ST_IDLE;
            end
        endcase
    end

    a_send_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rfce_pkg::ST_SEND) |-> (r_count != '0 && r_idx < r_count))
        else $error("Echo index outside the stored frame.");

    a_read_then_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rfce_pkg::ST_READ) |=> (r_state == rfce_pkg::ST_SEND))
        else $error("Store read not followed by a result.");

    a_echo_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rfce_pkg::ST_SEND && !i_out_stall && w_last)
            |=> (r_state == rfce_pkg::ST_IDLE && r_count == '0 && !r_marker))
        else $error("Frame not cleared after the final echoed byte.");

    a_no_marker_in_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != rfce_pkg::ST_IDLE) |-> !r_marker)
        else $error("Marker flag set during echo.");

endmodule

FILE: rtl/rx_frame_collect_and_echo.sv
// Top level of the framed receive buffer with echo.
// The input channel (i_valid, o_stall) carries one received byte per
// transaction with its timeout and read-error flags. Bytes with a read error
// are dropped. Other bytes are stored until the marker 0x55; the next byte
// closes the frame, and if it is 0xAA without a timeout the stored payload is
// echoed on the output channel (o_valid, i_stall), oldest byte first, with
// o_last on the final byte. Any other closing byte discards the frame, and
// a frame that fills the store up to DEPTH bytes is discarded as well.
// A stored byte, a marker or a discarded frame never stalls the input.
// After the closing byte, each result is one registered read of the payload
// store: the sequencer reads the byte in a read state, presents it in a send
// state and, once it is taken, goes back to read the next byte. o_stall is
// high for the whole echo. When the receiver stalls, the result holds and the
// sequencer waits. Synchronous reset empties the frame and returns to idle at
// once; the store itself is not cleared.
module rx_frame_collect_and_echo (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_timeout_flag,
    input  logic       i_read_error,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_tx_byte,
    output logic       o_last
);

    rfce_pkg::t_buf_req w_buf;

    rfce_ctl u_ctl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_rx_byte      (i_rx_byte),
        .i_timeout_flag (i_timeout_flag),
        .i_read_error   (i_read_error),
        .o_stall        (o_stall),
        .i_out_stall    (i_stall),
        .o_out_valid    (o_valid),
        .o_last         (o_last),
        .o_buf          (w_buf)
    );

    rfce_buf u_buf (
        .i_clk     (i_clk),
        .i_req     (w_buf),
        .o_rd_data (o_tx_byte)
    );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the framed receive buffer with echo.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 470;
    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD = 400;
    localparam int DRAIN_CYCLES = 2 * rfce_pkg::DEPTH + 8;

    typedef struct {
        logic [7:0]  data;
        logic        tmo;
        logic        rerr;
        int unsigned gap;
    } t_rx_item;

    typedef struct {
        logic [7:0] data;
        logic       is_last;
    } t_echo_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_timeout_flag = 1'b0;
    logic       i_read_error = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_tx_byte;
    logic       o_last;

    t_rx_item   stim_q[$];
    t_echo_byte echo_q[$];
    t_rx_item   cur_item;

    logic [7:0]  frame_store[rfce_pkg::DEPTH];
    int unsigned frame_count = 0;
    bit          frame_marked = 1'b0;

    int unsigned gap_max = 0;
    int unsigned n_items = 0;
    int unsigned n_accepted = 0;
    int unsigned n_taken = 0;
    int unsigned fails = 0;
    int unsigned hold_cnt = 0;
    int unsigned stall_left = 0;
    int unsigned long_left = 0;
    int unsigned idle_cycles = 0;
    bit          long_done = 1'b0;
    bit          rx_calm = 1'b0;

    rx_frame_collect_and_echo DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .i_timeout_flag (i_timeout_flag),
        .i_read_error   (i_read_error),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_tx_byte      (o_tx_byte),
        .o_last         (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void track_rx(t_rx_item it);
        t_echo_byte eb;
        if (it.rerr) return;
        if (frame_marked) begin
            if (it.data == rfce_pkg::CLOSE_BYTE && !it.tmo) begin
                for (int unsigned k = 0; k < frame_count; k++) begin
                    eb.data = frame_store[rfce_pkg::CW'(k)];
                    eb.is_last = (k + 1 == frame_count);
                    echo_q.push_back(eb);
                end
            end
            frame_count = 0;
            frame_marked = 1'b0;
        end else if (it.data == rfce_pkg::MARKER_BYTE) begin
            frame_marked = 1'b1;
        end else begin
            frame_store[rfce_pkg::CW'(frame_count)] = it.data;
            frame_count++;
            if (frame_count > rfce_pkg::DEPTH - 1) frame_count = 0;
        end
    endfunction

    function automatic void push_item(logic [7:0] data, logic tmo, logic rerr);
        t_rx_item it;
        it.data = data;
        it.tmo = tmo;
        it.rerr = rerr;
        it.gap = $urandom_range(0, gap_max);
        stim_q.push_back(it);
        n_items++;
    endfunction

    function automatic void push_payload(int unsigned len);
        logic [7:0] b;
        for (int unsigned k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            end
            b = 8'($urandom_range(0, 255));
            if (b == rfce_pkg::MARKER_BYTE) b = ~b;
            push_item(b, 1'($urandom_range(0, 1)), 1'b0);
        end
    endfunction

    always @(posedge i_clk) begin
        logic nv;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            hold_cnt = 0;
        end else begin
            nv = i_valid;
            if (i_valid && !o_stall) begin
                track_rx(cur_item);
                n_accepted++;
                nv = 1'b0;
            end
            if (!nv && stim_q.size() > 0) begin
                if (hold_cnt < stim_q[0].gap) begin
                    hold_cnt++;
                end else begin
                    cur_item = stim_q.pop_front();
                    hold_cnt = 0;
                    nv = 1'b1;
                    i_rx_byte <= cur_item.data;
                    i_timeout_flag <= cur_item.tmo;
                    i_read_error <= cur_item.rerr;
                end
            end
            i_valid <= nv;
        end
    end

    always @(posedge i_clk) begin
        t_echo_byte eb;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
            long_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                n_taken++;
                if (n_taken % 32 == 0) rx_calm = ($urandom_range(0, 2) == 0);
                if (echo_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("Unexpected result at %0t: tx_byte %02h last %0b",
                                 $time, o_tx_byte, o_last);
                    end
                end else begin
                    eb = echo_q.pop_front();
                    if (o_tx_byte !== eb.data || o_last !== eb.is_last) begin
                        fails++;
                        if (fails <= 10) begin
                            $display({"Mismatch at %0t: expected tx_byte %02h last %0b, ",
                                      "got tx_byte %02h last %0b"},
                                     $time, eb.data, eb.is_last, o_tx_byte, o_last);
                        end
                    end
                end
                stall_left = rx_calm ? 0 : $urandom_range(0, 16);
            end
            if (o_valid && !long_done && n_taken >= 40) begin
                long_done = 1'b1;
                long_left = LONG_HOLD;
            end
            if (long_left > 0) begin
                long_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned kind;
        int unsigned len;
        logic [7:0]  b;

        // Directed frames: empty frame, extremes, timeouts, read errors,
        // wrong closing byte and repeated marker.
        gap_max = 0;
        push_item(rfce_pkg::MARKER_BYTE, 1'b0, 1'b0);
        push_item(rfce_pkg::CLOSE_BYTE, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(rfce_pkg::MARKER_BYTE, 1'b0, 1'b1);
        push_item(rfce_pkg::CLOSE_BYTE, 1'b0, 1'b0);
        push_item(rfce_pkg::MARKER_BYTE, 1'b1, 1'b0);
        push_item(rfce_pkg::CLOSE_BYTE, 1'b0, 1'b0);
        gap_max = 16;
        push_item(8'h7E, 1'b0, 1'b0);
        push_item(rfce_pkg::MARKER_BYTE, 1'b0, 1'b0);
        push_item(rfce_pkg::CLOSE_BYTE, 1'b1, 1'b0);
        push_item(8'h33, 1'b0, 1'b0);
        push_item(rfce_pkg::MARKER_BYTE, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h44, 1'b1, 1'b0);
        push_item(rfce_pkg::MARKER_BYTE, 1'b0, 1'b0);
        push_item(rfce_pkg::MARKER_BYTE, 1'b0, 1'b0);
        push_item(8'h81, 1'b0, 1'b0);
        push_item(rfce_pkg::MARKER_BYTE, 1'b1, 1'b1);
        push_item(rfce_pkg::MARKER_BYTE, 1'b0, 1'b0);
        push_item(rfce_pkg::CLOSE_BYTE, 1'b0, 1'b1);
        push_item(rfce_pkg::CLOSE_BYTE, 1'b0, 1'b0);

        // A full frame, then one that overflows and restarts.
        push_payload(rfce_pkg::DEPTH - 1);
        push_item(rfce_pkg::MARKER_BYTE, 1'b0, 1'b0);
        push_item(rfce_pkg::CLOSE_BYTE, 1'b0, 1'b0);
        gap_max = 0;
        push_payload(rfce_pkg::DEPTH + 2);
        push_item(rfce_pkg::MARKER_BYTE, 1'b0, 1'b0);
        push_item(rfce_pkg::CLOSE_BYTE, 1'b0, 1'b0);

        while (n_items < ITEM_TARGET) begin
            kind = $urandom_range(0, 19);
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
            case ($urandom_range(0, 19))
                0: len = $urandom_range(rfce_pkg::DEPTH - 4, rfce_pkg::DEPTH + 6);
                1, 2, 3, 4: len = $urandom_range(9, 40);
                default: len = $urandom_range(0, 8);
            endcase
            if (kind < 14) begin
                push_payload(len);
                push_item(rfce_pkg::MARKER_BYTE, 1'($urandom_range(0, 1)), 1'b0);
                push_item(rfce_pkg::CLOSE_BYTE, 1'b0, 1'b0);
            end else if (kind < 17) begin
                push_payload(len % 12);
                push_item(rfce_pkg::MARKER_BYTE, 1'($urandom_range(0, 1)), 1'b0);
                case ($urandom_range(0, 2))
                    0: begin
                        b = 8'($urandom_range(0, 255));
                        if (b == rfce_pkg::CLOSE_BYTE) b = b ^ 8'h01;
                        push_item(b, 1'($urandom_range(0, 1)), 1'b0);
                    end
                    1: push_item(rfce_pkg::CLOSE_BYTE, 1'b1, 1'b0);
                    default: push_item(rfce_pkg::MARKER_BYTE, 1'($urandom_range(0, 1)), 1'b0);
                endcase
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              $urandom_range(0, 3) == 0);
                end
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_items || echo_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fails == 0 && echo_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: rx_frame_collect_and_echo.f
rtl/rfce_pkg.sv
rtl/rfce_buf.sv
rtl/rfce_ctl.sv
rtl/rx_frame_collect_and_echo.sv
tb/tb.sv
